>>> hw/rtl/plx_pkg.sv
`default_nettype none
package plx_pkg;

  localparam int KwBuf  = 12;
  localparam int KwIdxW = $clog2(KwBuf);
  localparam int IdLenW = $clog2(KwBuf + 2);
  localparam int NumKw  = 39;

  localparam logic [62:0] ValueMax = {63{1'b1}};
  localparam logic [5:0]  FracMax  = 6'd63;

  localparam logic [5:0] KindEof    = 6'd0;
  localparam logic [5:0] KindIdent  = 6'd1;
  localparam logic [5:0] KindKey0   = 6'd2;
  localparam logic [5:0] KindString = 6'd41;
  localparam logic [5:0] KindChar   = 6'd42;
  localparam logic [5:0] KindInt    = 6'd43;
  localparam logic [5:0] KindReal   = 6'd44;
  localparam logic [5:0] KindAssign = 6'd45;
  localparam logic [5:0] KindLe     = 6'd46;
  localparam logic [5:0] KindNe     = 6'd47;
  localparam logic [5:0] KindGe     = 6'd48;
  localparam logic [5:0] KindEq     = 6'd49;
  localparam logic [5:0] KindColon  = 6'd50;
  localparam logic [5:0] KindSingle = 6'd51;
  localparam logic [5:0] KindText   = 6'd52;

  // Keyword text is right-justified, so the first character sits in the highest used byte.
  localparam logic [95:0] KwText [NumKw] = '{
    "DECLARE", "INTEGER", "BOOLEAN", "REAL", "STRING", "CHAR", "TRUE", "FALSE",
    "INPUT", "OUTPUT", "IF", "THEN", "ELSE", "ENDIF", "WHILE", "DO", "ENDWHILE",
    "REPEAT", "UNTIL", "FOR", "TO", "STEP", "NEXT", "ARRAY", "OF", "DIV", "MOD",
    "AND", "OR", "NOT", "FUNCTION", "ENDFUNCTION", "PROCEDURE", "ENDPROCEDURE",
    "RETURN", "RETURNS", "CALL", "BYREF", "BYVAL"
  };
  localparam int KwLen [NumKw] = '{
    7, 7, 7, 4, 6, 4, 4, 5, 5, 6, 2, 4, 4, 5, 5, 2, 8,
    6, 5, 3, 2, 4, 4, 5, 2, 3, 3, 3, 2, 3, 8, 11, 9, 12,
    6, 7, 4, 5, 5
  };

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [62:0] value;
    logic [5:0]  fraction_digits;
    logic [7:0]  text_char;
    logic [31:0] line;
    logic        token_error;
    logic        any_error;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  w0;
    out_word_t  w1;
  } push_t;

  function automatic logic [5:0] kw_lookup(input logic [7:0] ib [KwBuf],
                                           input logic [IdLenW-1:0] len);
    logic [5:0] kind;
    logic       hit;
    kind = KindIdent;
    for (int k = 0; k < NumKw; k++) begin
      hit = (int'(len) == KwLen[k]);
      for (int i = 0; i < KwBuf; i++) begin
        if (i < KwLen[k]) begin
          if (ib[i] != KwText[k][8*(KwLen[k]-1-i) +: 8]) hit = 1'b0;
        end
      end
      if (hit && kind == KindIdent) kind = 6'(int'(KindKey0) + k);
    end
    return kind;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/plx_fifo.sv
`default_nettype none
module plx_fifo import plx_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  push_t      push_i,
  output logic       room_o,
  output logic       valid_o,
  input  wire        ready_i,
  output out_word_t  data_o
);

  out_word_t  mem_q [4];
  logic [1:0] rp_q, wp_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 3'd0);
  assign data_o  = mem_q[rp_q];
  // Room for two words, the most one input can make.
  assign room_o  = (cnt_q <= 3'd2);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wp_q] <= push_i.w0;
    if (push_i.cnt == 2'd2) mem_q[wp_q + 2'd1] <= push_i.w1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q  <= '0;
      wp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + push_i.cnt;
      if (pop) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, push_i.cnt} - {2'b0, pop};
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/plx_core.sv
`default_nettype none
module plx_core import plx_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         fire_i,
  input  in_word_t    word_i,
  input  wire         cfg_fire_i,
  input  wire  [31:0] cfg_data_i,
  output push_t       push_o
);

  localparam logic [3:0] MIdle = 4'd0, MIdent = 4'd1, MInt = 4'd2, MReal = 4'd3,
                         MStr = 4'd4, MCh1 = 4'd5, MCh2 = 4'd6, MChSkip = 4'd7,
                         MLt = 4'd8, MGt = 4'd9, MSlash = 4'd10, MComment = 4'd11;

  logic [3:0]        mode_q, mode_d;
  logic [31:0]       line_q, line_d;
  logic              any_q, any_d;
  logic [7:0]        ib_q [KwBuf];
  logic [7:0]        ib_d [KwBuf];
  logic [IdLenW-1:0] idlen_q, idlen_d;
  logic [62:0]       acc_q, acc_d;
  logic [5:0]        frac_q, frac_d;
  logic [7:0]        ch_q, ch_d;

  out_word_t  res [2];
  logic [1:0] cnt;
  logic [7:0] b;
  logic       is_alpha, is_digit, is_space, consumed;
  logic [66:0] acc_x10;
  logic [62:0] acc_next;
  logic [5:0]  kw_kind;

  function automatic out_word_t mk(input logic [5:0] kind, input logic [62:0] val,
                                   input logic [5:0] fd, input logic [7:0] tc,
                                   input logic err);
    out_word_t w;
    w = '0;
    w.kind = kind;
    w.value = val;
    w.fraction_digits = fd;
    w.text_char = tc;
    w.token_error = err;
    return w;
  endfunction

  assign b        = word_i.source_byte;
  assign is_alpha = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  assign is_digit = (b >= 8'h30 && b <= 8'h39);
  assign is_space = (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
  assign acc_x10  = {1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0} + {63'b0, b[3:0]};
  assign acc_next = (acc_x10[66:63] != 4'd0) ? ValueMax : acc_x10[62:0];
  assign kw_kind  = (idlen_q <= IdLenW'(KwBuf)) ? kw_lookup(ib_q, idlen_q) : KindIdent;

  always_comb begin
    mode_d = mode_q; line_d = line_q; any_d = any_q; ib_d = ib_q;
    idlen_d = idlen_q; acc_d = acc_q; frac_d = frac_q; ch_d = ch_q;
    res[0] = '0; res[1] = '0; cnt = 2'd0; consumed = 1'b0;
    if (word_i.end_of_input) begin
      unique case (mode_q)
        MIdent:       begin res[cnt[0]] = mk(kw_kind, '0, '0, '0, 1'b0); cnt++; end
        MInt:         begin res[cnt[0]] = mk(KindInt, acc_q, '0, '0, 1'b0); cnt++; end
        MReal:        begin res[cnt[0]] = mk(KindReal, acc_q, frac_q, '0, 1'b0); cnt++; end
        MStr:         begin res[cnt[0]] = mk(KindString, '0, '0, '0, 1'b1); cnt++; end
        MCh1:         begin res[cnt[0]] = mk(KindChar, '0, '0, "?", 1'b1); cnt++; end
        MCh2, MChSkip: begin res[cnt[0]] = mk(KindChar, '0, '0, ch_q, 1'b1); cnt++; end
        MLt:          begin res[cnt[0]] = mk(KindSingle, '0, '0, "<", 1'b0); cnt++; end
        MGt:          begin res[cnt[0]] = mk(KindSingle, '0, '0, ">", 1'b0); cnt++; end
        MSlash:       begin res[cnt[0]] = mk(KindSingle, '0, '0, "/", 1'b0); cnt++; end
        default: ;
      endcase
      mode_d = MIdle;
      res[cnt[0]] = mk(KindEof, '0, '0, '0, 1'b0); cnt++;
    end else begin
      unique case (mode_q)
        MIdent: begin
          if (is_alpha || is_digit || b == "_") begin
            if (idlen_q < IdLenW'(KwBuf)) ib_d[idlen_q[KwIdxW-1:0]] = b;
            if (idlen_q <= IdLenW'(KwBuf)) idlen_d = idlen_q + 1'b1;
            res[cnt[0]] = mk(KindText, '0, '0, b, 1'b0); cnt++;
            consumed = 1'b1;
          end else begin
            res[cnt[0]] = mk(kw_kind, '0, '0, '0, 1'b0); cnt++;
          end
        end
        MInt: begin
          if (is_digit) begin
            acc_d = acc_next; consumed = 1'b1;
          end else if (b == ".") begin
            mode_d = MReal; frac_d = '0; consumed = 1'b1;
          end else begin
            res[cnt[0]] = mk(KindInt, acc_q, '0, '0, 1'b0); cnt++;
          end
        end
        MReal: begin
          if (is_digit) begin
            acc_d = acc_next;
            if (frac_q < FracMax) frac_d = frac_q + 6'd1;
            consumed = 1'b1;
          end else begin
            res[cnt[0]] = mk(KindReal, acc_q, frac_q, '0, 1'b0); cnt++;
          end
        end
        MStr: begin
          if (b == "\"") begin
            res[cnt[0]] = mk(KindString, '0, '0, '0, 1'b0); cnt++;
            mode_d = MIdle; consumed = 1'b1;
          end else if (b == 8'h0A) begin
            res[cnt[0]] = mk(KindString, '0, '0, '0, 1'b1); cnt++;
          end else begin
            res[cnt[0]] = mk(KindText, '0, '0, b, 1'b0); cnt++;
            consumed = 1'b1;
          end
        end
        MCh1: begin
          if (b == 8'h0A) begin
            res[cnt[0]] = mk(KindChar, '0, '0, "?", 1'b1); cnt++;
          end else begin
            ch_d = b; mode_d = MCh2; consumed = 1'b1;
          end
        end
        MCh2, MChSkip: begin
          if (b == 8'h27) begin
            res[cnt[0]] = mk(KindChar, '0, '0, ch_q, mode_q == MChSkip); cnt++;
            mode_d = MIdle; consumed = 1'b1;
          end else if (b == 8'h0A) begin
            res[cnt[0]] = mk(KindChar, '0, '0, ch_q, 1'b1); cnt++;
          end else begin
            mode_d = MChSkip; consumed = 1'b1;
          end
        end
        MLt: begin
          mode_d = MIdle; consumed = 1'b1;
          priority if (b == "-") begin
            res[cnt[0]] = mk(KindAssign, '0, '0, '0, 1'b0); cnt++;
          end else if (b == "=") begin
            res[cnt[0]] = mk(KindLe, '0, '0, '0, 1'b0); cnt++;
          end else if (b == ">") begin
            res[cnt[0]] = mk(KindNe, '0, '0, '0, 1'b0); cnt++;
          end else begin
            res[cnt[0]] = mk(KindSingle, '0, '0, "<", 1'b0); cnt++;
            consumed = 1'b0;
          end
        end
        MGt: begin
          mode_d = MIdle;
          if (b == "=") begin
            res[cnt[0]] = mk(KindGe, '0, '0, '0, 1'b0); cnt++;
            consumed = 1'b1;
          end else begin
            res[cnt[0]] = mk(KindSingle, '0, '0, ">", 1'b0); cnt++;
          end
        end
        MSlash: begin
          if (b == "/") begin
            mode_d = MComment; consumed = 1'b1;
          end else begin
            res[cnt[0]] = mk(KindSingle, '0, '0, "/", 1'b0); cnt++;
          end
        end
        MComment: begin
          consumed = !(b == 8'h0A || b == 8'h0D);
        end
        default: ;
      endcase
      // A byte the pending token refused is lexed afresh from idle.
      if (!consumed) begin
        mode_d = MIdle;
        priority if (is_space) begin
          if (b == 8'h0A) line_d = line_q + 32'd1;
        end else if (b == "\"") begin
          mode_d = MStr;
        end else if (b == 8'h27) begin
          mode_d = MCh1; ch_d = '0;
        end else if (is_alpha) begin
          mode_d = MIdent; ib_d[0] = b; idlen_d = IdLenW'(1);
          res[cnt[0]] = mk(KindText, '0, '0, b, 1'b0); cnt++;
        end else if (is_digit) begin
          mode_d = MInt; acc_d = {59'b0, b[3:0]}; frac_d = '0;
        end else if (b == "<") begin
          mode_d = MLt;
        end else if (b == ">") begin
          mode_d = MGt;
        end else if (b == "=") begin
          res[cnt[0]] = mk(KindEq, '0, '0, '0, 1'b0); cnt++;
        end else if (b == ":") begin
          res[cnt[0]] = mk(KindColon, '0, '0, '0, 1'b0); cnt++;
        end else if (b == "/") begin
          mode_d = MSlash;
        end else begin
          res[cnt[0]] = mk(KindSingle, '0, '0, b, 1'b0); cnt++;
        end
      end
    end
    res[0].line = line_q;
    res[1].line = line_q;
    res[0].any_error = any_q || res[0].token_error;
    res[1].any_error = res[0].any_error || res[1].token_error;
    res[0].last = (cnt == 2'd1);
    res[1].last = 1'b1;
    if (cnt != 2'd0) any_d = (cnt == 2'd2) ? res[1].any_error : res[0].any_error;
  end

  assign push_o.cnt = fire_i ? cnt : 2'd0;
  assign push_o.w0  = res[0];
  assign push_o.w1  = res[1];

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      ib_q    <= ib_d;
      idlen_q <= idlen_d;
      acc_q   <= acc_d;
      frac_q  <= frac_d;
      ch_q    <= ch_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MIdle;
      line_q <= 32'd1;
      any_q  <= 1'b0;
    end else if (cfg_fire_i) begin
      line_q <= cfg_data_i;
    end else if (fire_i) begin
      mode_q <= mode_d;
      line_q <= line_d;
      any_q  <= any_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pseudocode_lexer.sv
`default_nettype none
// Channel  Direction  Handshake                Word
// in       input      in_valid_i / in_ready_o  in_data_i (byte, end mark)
// out      output     out_valid_o / out_ready_i out_data_o (token fields)
// cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (start line)
//
// One input byte is lexed in the cycle it is accepted and its up to two result
// words land in a four-entry output queue. Input is held off unless the queue
// has room for two words, else a byte is taken every cycle; the output drains
// one word per cycle when read. Reset puts the lexer idle at line 1.
module pseudocode_lexer import plx_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output out_word_t   out_data_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [31:0] cfg_data_i
);

  push_t push;
  logic  room;

  assign in_ready_o  = room;
  assign cfg_ready_o = 1'b1;

  plx_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_valid_i && room),
    .word_i     (in_data_i),
    .cfg_fire_i (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .push_o     (push)
  );

  plx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule
`default_nettype wire
